[rtl/obpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package obpm_pkg;

    localparam int BOOK_DEPTH = 128;
    localparam int ADDR_W     = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

    localparam logic SIDE_ASK = 1'b0;
    localparam logic SIDE_BID = 1'b1;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
        logic [15:0] stock;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_MATCH_RD,
        ST_MATCH_EX
    } state_t;

    typedef struct packed {
        logic load_item;
        logic srch_rd;
        logic srch_upd;
        logic sh_rd;
        logic sh_wr;
        logic ins_wr;
        logic m_rd;
        logic m_exec;
    } cmd_t;

    typedef struct packed {
        logic rejected;
        logic srch_done;
        logic sh_done;
        logic out_full;
    } status_t;

    // physical slot of logical index idx in a ring starting at head
    function automatic logic [ADDR_W-1:0] book_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(BOOK_DEPTH)) begin
            sum = sum - (CNT_W+1)'(BOOK_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/obpm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module obpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/obpm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module obpm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire obpm_pkg::status_t status,
    output obpm_pkg::cmd_t         cmd
);

    obpm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= obpm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            obpm_pkg::ST_IDLE: begin
                if (s_valid) state_next = obpm_pkg::ST_SRCH;
            end
            obpm_pkg::ST_SRCH: begin
                if (status.rejected)       state_next = obpm_pkg::ST_MATCH_RD;
                else if (status.srch_done) state_next = obpm_pkg::ST_SHIFT;
                else                       state_next = obpm_pkg::ST_SRCH_CMP;
            end
            obpm_pkg::ST_SRCH_CMP: state_next = obpm_pkg::ST_SRCH;
            obpm_pkg::ST_SHIFT: begin
                if (status.sh_done) state_next = obpm_pkg::ST_MATCH_RD;
                else                state_next = obpm_pkg::ST_SHIFT_WR;
            end
            obpm_pkg::ST_SHIFT_WR: state_next = obpm_pkg::ST_SHIFT;
            obpm_pkg::ST_MATCH_RD: state_next = obpm_pkg::ST_MATCH_EX;
            obpm_pkg::ST_MATCH_EX: begin
                if (!status.out_full) state_next = obpm_pkg::ST_IDLE;
            end
            default: state_next = obpm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            obpm_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            obpm_pkg::ST_SRCH: begin
                cmd.srch_rd = !status.rejected && !status.srch_done;
            end
            obpm_pkg::ST_SRCH_CMP: cmd.srch_upd = 1'b1;
            obpm_pkg::ST_SHIFT: begin
                cmd.ins_wr = status.sh_done;
                cmd.sh_rd  = !status.sh_done;
            end
            obpm_pkg::ST_SHIFT_WR: cmd.sh_wr = 1'b1;
            obpm_pkg::ST_MATCH_RD: cmd.m_rd = 1'b1;
            obpm_pkg::ST_MATCH_EX: cmd.m_exec = !status.out_full;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/obpm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module obpm_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire obpm_pkg::cmd_t cmd,
    output obpm_pkg::status_t   status,
    input  wire logic           in_side,
    input  wire logic [15:0]    in_stock,
    input  wire logic [31:0]    in_price,
    input  wire logic [31:0]    in_qty,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                out_deal_made,
    output logic [15:0]         out_deal_stock,
    output logic [31:0]         out_deal_price,
    output logic [31:0]         out_deal_qty,
    output logic                out_rejected
);

    localparam int AW = obpm_pkg::ADDR_W;
    localparam int CW = obpm_pkg::CNT_W;

    logic          side_reg;
    logic [15:0]   stock_reg;
    logic [31:0]   price_reg, qty_reg;
    logic          rej_reg;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [AW-1:0] head_a_reg, head_a_next, head_b_reg, head_b_next;
    logic [CW-1:0] lo_reg, hi_reg, idx_reg;
    logic          oval_reg;
    logic          o_made_reg, o_rej_reg;
    logic [15:0]   o_stock_reg;
    logic [31:0]   o_price_reg, o_qty_reg;

    logic [CW-1:0]  ridx;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid;
    logic           rd_en, keep;
    logic [AW-1:0]  ra_addr, rb_addr, w_addr_a, w_addr_b;
    logic           we_a, we_b;
    obpm_pkg::entry_t wd_a, wd_b, rd_a, rd_b, rd_s, new_ent;
    logic           match;
    logic [31:0]    dqty;

    assign mid_sum = (CW+1)'(lo_reg) + (CW+1)'(hi_reg);
    assign mid     = mid_sum[CW:1];
    assign rd_s    = side_reg ? rd_b : rd_a;
    assign keep    = (side_reg == obpm_pkg::SIDE_BID) ? (rd_s.price >= price_reg)
                                                      : (rd_s.price <= price_reg);
    assign new_ent = '{price: price_reg, qty: qty_reg, stock: stock_reg};

    assign status.rejected  = rej_reg;
    assign status.srch_done = (lo_reg == hi_reg);
    assign status.sh_done   = (idx_reg == lo_reg);
    assign status.out_full  = oval_reg;

    assign match = (cnt_a_reg != '0) && (cnt_b_reg != '0) && (rd_b.price >= rd_a.price);
    assign dqty  = (rd_a.qty < rd_b.qty) ? rd_a.qty : rd_b.qty;

    always_comb begin
        ridx = '0;
        if (cmd.srch_rd) ridx = mid;
        if (cmd.sh_rd)   ridx = idx_reg - CW'(1);
        rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.m_rd;
        ra_addr = obpm_pkg::book_addr(head_a_reg, ridx);
        rb_addr = obpm_pkg::book_addr(head_b_reg, ridx);
    end

    always_comb begin
        we_a        = 1'b0;
        we_b        = 1'b0;
        w_addr_a    = head_a_reg;
        w_addr_b    = head_b_reg;
        wd_a        = rd_a;
        wd_b        = rd_b;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        if (cmd.sh_wr) begin
            we_a     = !side_reg;
            we_b     = side_reg;
            w_addr_a = obpm_pkg::book_addr(head_a_reg, idx_reg);
            w_addr_b = obpm_pkg::book_addr(head_b_reg, idx_reg);
            wd_a     = rd_s;
            wd_b     = rd_s;
        end
        if (cmd.ins_wr) begin
            we_a     = !side_reg;
            we_b     = side_reg;
            w_addr_a = obpm_pkg::book_addr(head_a_reg, lo_reg);
            w_addr_b = obpm_pkg::book_addr(head_b_reg, lo_reg);
            wd_a     = new_ent;
            wd_b     = new_ent;
            if (side_reg) cnt_b_next = cnt_b_reg + CW'(1);
            else          cnt_a_next = cnt_a_reg + CW'(1);
        end
        if (cmd.m_exec && match) begin
            // larger offer keeps the remainder, smaller leaves the book; on equal quantities both leave
            if (rd_b.qty > rd_a.qty) begin
                we_b        = 1'b1;
                wd_b.qty    = rd_b.qty - dqty;
                head_a_next = obpm_pkg::book_addr(head_a_reg, CW'(1));
                cnt_a_next  = cnt_a_reg - CW'(1);
            end else if (rd_b.qty < rd_a.qty) begin
                we_a        = 1'b1;
                wd_a.qty    = rd_a.qty - dqty;
                head_b_next = obpm_pkg::book_addr(head_b_reg, CW'(1));
                cnt_b_next  = cnt_b_reg - CW'(1);
            end else begin
                head_a_next = obpm_pkg::book_addr(head_a_reg, CW'(1));
                cnt_a_next  = cnt_a_reg - CW'(1);
                head_b_next = obpm_pkg::book_addr(head_b_reg, CW'(1));
                cnt_b_next  = cnt_b_reg - CW'(1);
            end
        end
    end

    obpm_ram #(.WIDTH(obpm_pkg::ENTRY_W), .DEPTH(obpm_pkg::BOOK_DEPTH)) u_ask_ram (
        .aclk    (aclk),
        .wr_en   (we_a),
        .wr_addr (w_addr_a),
        .wr_data (wd_a),
        .rd_en   (rd_en),
        .rd_addr (ra_addr),
        .rd_data (rd_a)
    );

    obpm_ram #(.WIDTH(obpm_pkg::ENTRY_W), .DEPTH(obpm_pkg::BOOK_DEPTH)) u_bid_ram (
        .aclk    (aclk),
        .wr_en   (we_b),
        .wr_addr (w_addr_b),
        .wr_data (wd_b),
        .rd_en   (rd_en),
        .rd_addr (rb_addr),
        .rd_data (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            head_a_reg <= '0;
            head_b_reg <= '0;
            oval_reg   <= 1'b0;
        end else begin
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
            if (cmd.m_exec)     oval_reg <= 1'b1;
            else if (out_ready) oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            side_reg  <= in_side;
            stock_reg <= in_stock;
            price_reg <= in_price;
            qty_reg   <= in_qty;
            rej_reg   <= (in_side ? cnt_b_reg : cnt_a_reg) == CW'(obpm_pkg::BOOK_DEPTH);
            lo_reg    <= '0;
            hi_reg    <= in_side ? cnt_b_reg : cnt_a_reg;
            idx_reg   <= in_side ? cnt_b_reg : cnt_a_reg;
        end
        if (cmd.srch_upd) begin
            if (keep) lo_reg <= mid + CW'(1);
            else      hi_reg <= mid;
        end
        if (cmd.sh_wr) begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (cmd.m_exec) begin
            o_made_reg  <= match;
            o_stock_reg <= match ? rd_b.stock : 16'd0;
            o_price_reg <= match ? rd_a.price : 32'd0;
            o_qty_reg   <= match ? dqty : 32'd0;
            o_rej_reg   <= rej_reg;
        end
    end

    assign out_valid      = oval_reg;
    assign out_deal_made  = o_made_reg;
    assign out_deal_stock = o_stock_reg;
    assign out_deal_price = o_price_reg;
    assign out_deal_qty   = o_qty_reg;
    assign out_rejected   = o_rej_reg;

endmodule
`default_nettype wire

[rtl/order_book_price_match_top.sv]
// steps: binary search over the offers on that side, then the entries behind the insert point
// move up one at a time, the offer is inserted, and the match is read, then executed
// a rejected offer skips the search and the insert and goes straight to the match
// one item at a time: a new item is taken only once the last has left the match step,
// which waits while the output register is full; the shift loop sets the worst case
// reset: synchronous active-low aresetn empties both books and the output register
`timescale 1ns / 1ps
`default_nettype none
module order_book_price_match_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_offer_side,
    input  wire logic [15:0] s_offer_stock,
    input  wire logic [31:0] s_offer_price,
    input  wire logic [31:0] s_offer_quantity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_deal_made,
    output logic [15:0]      m_deal_stock,
    output logic [31:0]      m_deal_price,
    output logic [31:0]      m_deal_quantity,
    output logic             m_offer_rejected
);

    obpm_pkg::cmd_t    cmd;
    obpm_pkg::status_t status;

    obpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    obpm_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_side        (s_offer_side),
        .in_stock       (s_offer_stock),
        .in_price       (s_offer_price),
        .in_qty         (s_offer_quantity),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_deal_made  (m_deal_made),
        .out_deal_stock (m_deal_stock),
        .out_deal_price (m_deal_price),
        .out_deal_qty   (m_deal_quantity),
        .out_rejected   (m_offer_rejected)
    );

endmodule
`default_nettype wire

[rtl/obpm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module obpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_deal_made,
    input wire logic [15:0] m_deal_stock,
    input wire logic [31:0] m_deal_price,
    input wire logic [31:0] m_deal_quantity
);

    a_no_deal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_deal_made) |->
            (m_deal_stock == 16'd0 && m_deal_price == 32'd0 && m_deal_quantity == 32'd0))
        else $error("no-deal item carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_deal_price) && $stable(m_deal_quantity))
        else $error("stalled result changed");

endmodule

bind order_book_price_match_top obpm_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_deal_made     (m_deal_made),
    .m_deal_stock    (m_deal_stock),
    .m_deal_price    (m_deal_price),
    .m_deal_quantity (m_deal_quantity)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH = obpm_pkg::BOOK_DEPTH;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        made;
        logic [15:0] stock;
        logic [31:0] price;
        logic [31:0] qty;
        logic        rejected;
    } deal_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_offer_side = 1'b0;
    logic [15:0] s_offer_stock = '0;
    logic [31:0] s_offer_price = '0;
    logic [31:0] s_offer_quantity = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_deal_made;
    logic [15:0] m_deal_stock;
    logic [31:0] m_deal_price;
    logic [31:0] m_deal_quantity;
    logic        m_offer_rejected;

    order_book_price_match_top dut (.*);

    always #6 aclk = ~aclk;

    // shadow books, entry 0 best
    logic [31:0] ask_px[$], ask_qt[$], bid_px[$], bid_qt[$];
    logic [15:0] ask_sk[$], bid_sk[$];
    deal_t       pending_deals[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    function automatic deal_t match_offer(logic side, logic [15:0] stock,
                                          logic [31:0] price, logic [31:0] qty);
        deal_t d;
        int pos;
        logic [31:0] aq, bq;
        d = '0;
        pos = 0;
        if (side == obpm_pkg::SIDE_ASK) begin
            if (ask_px.size() >= DEPTH) d.rejected = 1'b1;
            else begin
                while (pos < ask_px.size() && ask_px[pos] <= price) pos++;
                ask_px.insert(pos, price);
                ask_qt.insert(pos, qty);
                ask_sk.insert(pos, stock);
            end
        end else begin
            if (bid_px.size() >= DEPTH) d.rejected = 1'b1;
            else begin
                while (pos < bid_px.size() && bid_px[pos] >= price) pos++;
                bid_px.insert(pos, price);
                bid_qt.insert(pos, qty);
                bid_sk.insert(pos, stock);
            end
        end
        if (ask_px.size() > 0 && bid_px.size() > 0 && bid_px[0] >= ask_px[0]) begin
            aq = ask_qt[0];
            bq = bid_qt[0];
            d.made = 1'b1;
            d.stock = bid_sk[0];
            d.price = ask_px[0];
            d.qty = (aq < bq) ? aq : bq;
            if (bq > aq) begin
                bid_qt[0] = bq - aq;
                void'(ask_px.pop_front()); void'(ask_qt.pop_front());
                void'(ask_sk.pop_front());
            end else if (bq < aq) begin
                ask_qt[0] = aq - bq;
                void'(bid_px.pop_front()); void'(bid_qt.pop_front());
                void'(bid_sk.pop_front());
            end else begin
                void'(ask_px.pop_front()); void'(ask_qt.pop_front());
                void'(ask_sk.pop_front());
                void'(bid_px.pop_front()); void'(bid_qt.pop_front());
                void'(bid_sk.pop_front());
            end
        end
        return d;
    endfunction

    task automatic send_offer(logic side, logic [15:0] stock, logic [31:0] price,
                              logic [31:0] qty);
        // bursty sender
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
        if (gap_left > 0) s_valid <= 1'b0;
        while (gap_left > 0) begin
            @(posedge aclk);
            gap_left--;
        end
        burst_left--;
        s_valid <= 1'b1;
        s_offer_side <= side;
        s_offer_stock <= stock;
        s_offer_price <= price;
        s_offer_quantity <= qty;
        do @(posedge aclk); while (!s_ready);
        pending_deals.push_back(match_offer(side, stock, price, qty));
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        while (pending_deals.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed;
        send_offer(obpm_pkg::SIDE_BID, 16'h0001, 32'd10, 32'd5);      // empty ask side
        send_offer(obpm_pkg::SIDE_ASK, 16'hffff, 32'd11, 32'd5);      // no cross
        send_offer(obpm_pkg::SIDE_ASK, 16'h0002, 32'd9, 32'd3);       // bid larger
        send_offer(obpm_pkg::SIDE_ASK, 16'h0003, 32'd10, 32'd2);      // equal quantities
        send_offer(obpm_pkg::SIDE_BID, 16'hffff, 32'hffffffff, 32'hffffffff);  // bid larger
        send_offer(obpm_pkg::SIDE_ASK, 16'h0004, 32'd0, 32'd0);       // zero quantity
        send_offer(obpm_pkg::SIDE_BID, 16'h0005, 32'd0, 32'd0);
        send_offer(obpm_pkg::SIDE_ASK, 16'h0006, 32'd0, 32'd0);
        send_offer(obpm_pkg::SIDE_BID, 16'h0007, 32'd0, 32'd1);
        send_offer(obpm_pkg::SIDE_ASK, 16'h0008, 32'hffffffff, 32'd1);
        send_offer(obpm_pkg::SIDE_BID, 16'h0009, 32'hffffffff, 32'd1);
        // equal ask prices keep arrival order
        send_offer(obpm_pkg::SIDE_ASK, 16'h0010, 32'd50, 32'd1);
        send_offer(obpm_pkg::SIDE_ASK, 16'h0011, 32'd50, 32'd1);
        send_offer(obpm_pkg::SIDE_BID, 16'h0012, 32'd50, 32'd1);
        send_offer(obpm_pkg::SIDE_BID, 16'h0013, 32'd50, 32'd1);
        wait_drained();
    endtask

    task automatic test_full_book;
        int i;
        // fill bids that never cross, then overflow
        for (i = 0; i < DEPTH + 3; i++)
            send_offer(obpm_pkg::SIDE_BID, 16'($urandom), 32'($urandom_range(0, 40)), 32'd7);
        send_offer(obpm_pkg::SIDE_ASK, 16'h0aaa, 32'hfffffff0, 32'd1);
        // drain bids with crossing asks
        for (i = 0; i < DEPTH + 4; i++)
            send_offer(obpm_pkg::SIDE_ASK, 16'($urandom), 32'd0, 32'd7);
        for (i = 0; i < DEPTH + 2; i++)
            send_offer(obpm_pkg::SIDE_ASK, 16'($urandom), 32'hffffffff - i, 32'd3);
        send_offer(obpm_pkg::SIDE_BID, 16'h0bbb, 32'hffffffff, 32'd500);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int i;
        logic [31:0] px, qt;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: px = $urandom;
                1: px = 32'hffffffff - $urandom_range(0, 3);
                default: px = 32'd100 + $urandom_range(0, 20);
            endcase
            case ($urandom_range(0, 9))
                0: qt = $urandom;
                1: qt = 32'd0;
                default: qt = $urandom_range(1, 50);
            endcase
            send_offer(1'($urandom), 16'($urandom), px, qt);
            if (i == n / 2) wait_drained();
        end
        wait_drained();
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 7) < 5) || (($urandom_range(0, 3) == 0));
    end

    always @(posedge aclk) begin
        deal_t exp_deal;
        if (aresetn && m_valid && m_ready) begin
            if (pending_deals.size() == 0) begin
                $display("%0t: unexpected item made=%0d", $time, m_deal_made);
                errors++;
            end else begin
                exp_deal = pending_deals.pop_front();
                if (m_deal_made !== exp_deal.made) begin
                    $display("%0t: deal_made exp %0d got %0d", $time, exp_deal.made,
                             m_deal_made);
                    errors++;
                end
                if (m_deal_stock !== exp_deal.stock) begin
                    $display("%0t: deal_stock exp %0h got %0h", $time, exp_deal.stock,
                             m_deal_stock);
                    errors++;
                end
                if (m_deal_price !== exp_deal.price) begin
                    $display("%0t: deal_price exp %0h got %0h", $time, exp_deal.price,
                             m_deal_price);
                    errors++;
                end
                if (m_deal_quantity !== exp_deal.qty) begin
                    $display("%0t: deal_quantity exp %0h got %0h", $time, exp_deal.qty,
                             m_deal_quantity);
                    errors++;
                end
                if (m_offer_rejected !== exp_deal.rejected) begin
                    $display("%0t: offer_rejected exp %0d got %0d", $time,
                             exp_deal.rejected, m_offer_rejected);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("order_book_price_match_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_book();
        test_random(990);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending_deals.size() == 0) begin
            $display("order_book_price_match_top: match");
        end else begin
            $display("order_book_price_match_top: mismatch");
        end
        $finish;
    end
endmodule
